FILE: sv/dszs_pkg.sv
// dszs_pkg: shared types and constants of the depth swipe zone sequencer
// used by dszs_hit and depth_swipe_zone_sequencer; depends on nothing

package dszs_pkg;

    localparam int IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_ZONE_COUNT    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ZONE_WIDTH    = 3'd1;
    localparam logic [IDX_W-1:0] REG_BAND_TOP      = 3'd2;
    localparam logic [IDX_W-1:0] REG_BAND_HEIGHT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_NEAR_LIMIT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_FRAME_PERIOD  = 3'd5;
    localparam logic [IDX_W-1:0] REG_TIMEOUT_LIMIT = 3'd6;

    // register reset values
    localparam logic [4:0]  RST_ZONE_COUNT    = 5'd4;
    localparam logic [9:0]  RST_ZONE_WIDTH    = 10'd128;
    localparam logic [8:0]  RST_BAND_TOP      = 9'd0;
    localparam logic [9:0]  RST_BAND_HEIGHT   = 10'd128;
    localparam logic [15:0] RST_NEAR_LIMIT    = 16'd1200;
    localparam logic [15:0] RST_FRAME_PERIOD  = 16'd33;
    localparam logic [15:0] RST_TIMEOUT_LIMIT = 16'd3000;

    // hard ceiling on the zone count
    localparam logic [4:0] ZONE_CEIL = 5'd16;

    typedef struct packed {
        logic [4:0]  zone_count;
        logic [9:0]  zone_width;
        logic [8:0]  band_top;
        logic [9:0]  band_height;
        logic [15:0] near_limit;
        logic [15:0] frame_period;
        logic [15:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [15:0] depth;
        logic        frame_end;
    } pixel_t;

endpackage

FILE: sv/dszs_hit.sv
// dszs_hit: per-pixel hit test against the frame, the band, the awaited zone and the near limit
// depends on dszs_pkg

module dszs_hit #(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512
) (
    input  dszs_pkg::cfg_t   cfg,
    input  dszs_pkg::pixel_t pix,
    input  logic [9:0]       zone_left,
    output logic             hit
);

    localparam logic [12:0] FW = 13'(FRAME_WIDTH);
    localparam logic [12:0] FH = 13'(FRAME_HEIGHT);

    logic        in_frame;
    logic        in_band;
    logic        in_zone;
    logic        near;
    logic [10:0] band_end;
    logic [10:0] zone_end;

    assign band_end = {2'b00, cfg.band_top} + {1'b0, cfg.band_height};
    assign zone_end = {1'b0, zone_left} + {1'b0, cfg.zone_width};

    assign in_frame = ({4'b0000, pix.pixel_x} < FW) && ({4'b0000, pix.pixel_y} < FH);
    assign in_band  = (pix.pixel_y >= cfg.band_top) && ({2'b00, pix.pixel_y} < band_end);
    assign in_zone  = ({1'b0, pix.pixel_x} >= zone_left) && ({2'b00, pix.pixel_x} < zone_end);
    assign near     = (pix.depth != 16'd0) && (pix.depth < cfg.near_limit);

    assign hit = in_frame && in_band && in_zone && near;

endmodule

FILE: sv/depth_swipe_zone_sequencer.sv
// depth_swipe_zone_sequencer: top level, config registers, pixel register,
// zone state and result register; depends on dszs_pkg and dszs_hit

// Takes one depth pixel per clock in raster order and reports one result
// per frame, on the pixel that carries tlast. A pixel is captured in an
// input register and then resolved against the zone state, and the result of
// a frame is written from there into the result register on the master side.
// Pixels without tlast never stall; a frame-end pixel waits only while the
// result register still holds an untaken result. Sustained rate is one pixel
// per cycle while no frame-end pixel waits. Configuration writes take effect
// at once and are meant for idle periods.

module depth_swipe_zone_sequencer #(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512,
    parameter int MAX_ZONES    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel_x[8:0], pixel_y[17:9], depth[33:18], zeros
    input  logic        s_tlast,   // frame_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // swipe_done[0], timed_out[1], zone_now[5:2], zeros
);

    localparam logic [4:0] ZONE_CAP =
        (MAX_ZONES > 16) ? dszs_pkg::ZONE_CEIL : 5'(MAX_ZONES);

    dszs_pkg::cfg_t   cfg_reg;
    dszs_pkg::pixel_t pix_reg;
    logic             pix_valid_reg;

    logic [3:0]  zone_index_reg, zone_index_next;
    logic [9:0]  zone_left_reg,  zone_left_next;
    logic [16:0] zone_timer_reg, zone_timer_next;
    logic        hit_seen_reg,   hit_seen_next;

    logic        out_valid_reg;
    logic [7:0]  out_data_reg;

    logic        pix_hit;
    logic        advance;
    logic        out_free;
    logic [4:0]  eff_zones;
    logic [4:0]  next_zone;
    logic [16:0] timer_sum;
    logic        any_hit;
    logic        tout;
    logic        done;
    logic [13:0] left_prod;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zone_count    <= dszs_pkg::RST_ZONE_COUNT;
            cfg_reg.zone_width    <= dszs_pkg::RST_ZONE_WIDTH;
            cfg_reg.band_top      <= dszs_pkg::RST_BAND_TOP;
            cfg_reg.band_height   <= dszs_pkg::RST_BAND_HEIGHT;
            cfg_reg.near_limit    <= dszs_pkg::RST_NEAR_LIMIT;
            cfg_reg.frame_period  <= dszs_pkg::RST_FRAME_PERIOD;
            cfg_reg.timeout_limit <= dszs_pkg::RST_TIMEOUT_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dszs_pkg::REG_ZONE_COUNT:    cfg_reg.zone_count    <= cfg_data[4:0];
                dszs_pkg::REG_ZONE_WIDTH:    cfg_reg.zone_width    <= cfg_data[9:0];
                dszs_pkg::REG_BAND_TOP:      cfg_reg.band_top      <= cfg_data[8:0];
                dszs_pkg::REG_BAND_HEIGHT:   cfg_reg.band_height   <= cfg_data[9:0];
                dszs_pkg::REG_NEAR_LIMIT:    cfg_reg.near_limit    <= cfg_data;
                dszs_pkg::REG_FRAME_PERIOD:  cfg_reg.frame_period  <= cfg_data;
                dszs_pkg::REG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: a pixel without frame end always retires
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = pix_valid_reg && (!pix_reg.frame_end || out_free);
    assign s_tready = !pix_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            pix_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            pix_reg.pixel_x   <= s_tdata[8:0];
            pix_reg.pixel_y   <= s_tdata[17:9];
            pix_reg.depth     <= s_tdata[33:18];
            pix_reg.frame_end <= s_tlast;
        end
    end

    dszs_hit #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_hit (
        .cfg       (cfg_reg),
        .pix       (pix_reg),
        .zone_left (zone_left_reg),
        .hit       (pix_hit)
    );

    // frame-end decision
    always_comb
    begin
        eff_zones = cfg_reg.zone_count;
        if (eff_zones == 5'd0)
            eff_zones = 5'd1;
        if (eff_zones > ZONE_CAP)
            eff_zones = ZONE_CAP;

        any_hit   = hit_seen_reg || pix_hit;
        timer_sum = zone_timer_reg + {1'b0, cfg_reg.frame_period};
        tout      = timer_sum > {1'b0, cfg_reg.timeout_limit};
        next_zone = {1'b0, zone_index_reg} + 5'd1;
        done      = !tout && any_hit && (next_zone >= eff_zones);
        left_prod = next_zone[3:0] * cfg_reg.zone_width;

        zone_index_next = zone_index_reg;
        zone_left_next  = zone_left_reg;
        zone_timer_next = zone_timer_reg;
        hit_seen_next   = any_hit;

        if (pix_reg.frame_end)
        begin
            hit_seen_next   = 1'b0;
            zone_timer_next = timer_sum;
            if (tout || done)
            begin
                zone_index_next = 4'd0;
                zone_left_next  = 10'd0;
                zone_timer_next = 17'd0;
            end
            else if (any_hit)
            begin
                zone_index_next = next_zone[3:0];
                zone_left_next  = left_prod[9:0];
                zone_timer_next = 17'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_index_reg <= 4'd0;
            zone_left_reg  <= 10'd0;
            zone_timer_reg <= 17'd0;
            hit_seen_reg   <= 1'b0;
        end
        else if (advance)
        begin
            zone_index_reg <= zone_index_next;
            zone_left_reg  <= zone_left_next;
            zone_timer_reg <= zone_timer_next;
            hit_seen_reg   <= hit_seen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && pix_reg.frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pix_reg.frame_end)
        begin
            out_data_reg <= {2'b00, zone_index_next, tout, done};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: bench/depth_swipe_zone_sequencer_tb.sv
// depth_swipe_zone_sequencer_tb: self-checking bench for the depth swipe zone sequencer
// streams raster pixels with frame ends, predicts each frame result and checks the stream;
// depends on dszs_pkg and depth_swipe_zone_sequencer
`timescale 1ns / 100ps

module depth_swipe_zone_sequencer_tb;

    localparam int FRAME_W       = 512;
    localparam int FRAME_H       = 512;
    localparam int MAX_ZONES_TB  = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic       swipe_done;
        logic       timed_out;
        logic [3:0] zone_now;
    } swipe_res_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // pixel_x[8:0], pixel_y[17:9], depth[33:18], zeros
    logic        s_tlast = 1'b0; // frame_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // swipe_done[0], timed_out[1], zone_now[5:2], zeros

    // pixel source and expected frame results
    dszs_pkg::pixel_t pixel_q[$];
    swipe_res_t       swipe_q[$];

    // shadow of the block: registers and zone tracking state
    dszs_pkg::cfg_t cfg_m;
    logic [3:0]  zone_idx;
    logic [9:0]  zone_base;
    logic [16:0] zone_clock;
    logic        hit_flag;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int hold_left = 0;

    logic             px_fire = 1'b0;
    dszs_pkg::pixel_t tx_px;
    dszs_pkg::pixel_t rx_px;
    swipe_res_t got;
    swipe_res_t want;
    int err_cnt = 0;
    int cycles = 0;
    int n_px = 0;
    int n_frames = 0;
    int n_swipes = 0;
    int n_timeouts = 0;
    int n_setups = 1;
    dszs_pkg::cfg_t setup;

    depth_swipe_zone_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int eff_zones();
        int n;
        n = cfg_m.zone_count;
        if (n == 0)
            n = 1;
        if (n > MAX_ZONES_TB)
            n = MAX_ZONES_TB;
        return n;
    endfunction

    task automatic enter_zone(input logic [3:0] z);
        zone_idx = z;
        zone_base = z * cfg_m.zone_width;   // wraps at 10 bits
        zone_clock = '0;
    endtask

    task automatic predict_pixel(input dszs_pkg::pixel_t p);
        int x, y, d, top, bot, left, right;
        swipe_res_t r;
        x = p.pixel_x;
        y = p.pixel_y;
        d = p.depth;
        top = cfg_m.band_top;
        bot = top + int'(cfg_m.band_height);
        left = zone_base;
        right = left + int'(cfg_m.zone_width);
        if (x < FRAME_W && y < FRAME_H && y >= top && y < bot && x >= left && x < right &&
            d > 0 && d < int'(cfg_m.near_limit))
            hit_flag = 1'b1;
        if (!p.frame_end)
            return;
        r = '0;
        zone_clock = zone_clock + cfg_m.frame_period;
        // timeout wins over a hit in the same frame
        if (zone_clock > cfg_m.timeout_limit)
        begin
            r.timed_out = 1'b1;
            enter_zone(4'd0);
        end
        else if (hit_flag)
        begin
            if (int'(zone_idx) + 1 >= eff_zones())
            begin
                r.swipe_done = 1'b1;
                enter_zone(4'd0);
            end
            else
                enter_zone(zone_idx + 4'd1);
        end
        hit_flag = 1'b0;
        r.zone_now = zone_idx;
        swipe_q.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            dszs_pkg::REG_ZONE_COUNT:    cfg_m.zone_count = data[4:0];
            dszs_pkg::REG_ZONE_WIDTH:    cfg_m.zone_width = data[9:0];
            dszs_pkg::REG_BAND_TOP:      cfg_m.band_top = data[8:0];
            dszs_pkg::REG_BAND_HEIGHT:   cfg_m.band_height = data[9:0];
            dszs_pkg::REG_NEAR_LIMIT:    cfg_m.near_limit = data;
            dszs_pkg::REG_FRAME_PERIOD:  cfg_m.frame_period = data;
            dszs_pkg::REG_TIMEOUT_LIMIT: cfg_m.timeout_limit = data;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input dszs_pkg::cfg_t c);
        write_reg(dszs_pkg::REG_ZONE_COUNT, 16'(c.zone_count));
        write_reg(dszs_pkg::REG_ZONE_WIDTH, 16'(c.zone_width));
        write_reg(dszs_pkg::REG_BAND_TOP, 16'(c.band_top));
        write_reg(dszs_pkg::REG_BAND_HEIGHT, 16'(c.band_height));
        write_reg(dszs_pkg::REG_NEAR_LIMIT, c.near_limit);
        write_reg(dszs_pkg::REG_FRAME_PERIOD, c.frame_period);
        write_reg(dszs_pkg::REG_TIMEOUT_LIMIT, c.timeout_limit);
        @(negedge clk);
        cfg_we <= 1'b0;
        n_setups++;
    endtask

    task automatic add_px(input int x, input int y, input int d, input bit fe);
        dszs_pkg::pixel_t p;
        p.pixel_x = 9'(x);
        p.pixel_y = 9'(y);
        p.depth = 16'(d);
        p.frame_end = fe;
        pixel_q.push_back(p);
    endtask

    // frames of 1..8 pixels, mostly aimed at a zone inside the band with a near reading
    task automatic queue_frames(input int n_items);
        int left, len, zsel;
        dszs_pkg::pixel_t p;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(8, 1);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                p.pixel_x = 9'($urandom);
                p.pixel_y = 9'($urandom);
                p.depth = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom);
                if ($urandom_range(99) < 70)
                begin
                    zsel = $urandom_range(eff_zones() - 1);
                    if (cfg_m.zone_width != 0)
                        p.pixel_x = 9'(zsel * cfg_m.zone_width +
                                       $urandom_range(cfg_m.zone_width - 1));
                    if (cfg_m.band_height != 0)
                        p.pixel_y = 9'(cfg_m.band_top + $urandom_range(cfg_m.band_height - 1));
                    if (cfg_m.near_limit > 1)
                        p.depth = 16'($urandom_range(cfg_m.near_limit - 1, 1));
                end
                p.frame_end = (i == len - 1);
                pixel_q.push_back(p);
            end
            left -= len;
        end
    endtask

    // sender stays quiet until every pending frame result has been taken
    task automatic drain();
        while (pixel_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (swipe_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pixel driver
    always @(negedge clk)
    begin
        if (!s_tvalid || px_fire)
        begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                tx_px = pixel_q.pop_front();
                s_tdata <= {6'd0, tx_px.depth, tx_px.pixel_y, tx_px.pixel_x};
                s_tlast <= tx_px.frame_end;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tdata <= 40'({$urandom, $urandom});
                s_tlast <= 1'($urandom);
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_ack)
        begin
            hold_ack <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // monitor: predicts on each pixel transaction, checks each result transaction
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding", cycles, swipe_q.size());
            $display("[depth_swipe_zone_sequencer] ERROR");
            $finish;
        end
        px_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            rx_px.pixel_x = s_tdata[8:0];
            rx_px.pixel_y = s_tdata[17:9];
            rx_px.depth = s_tdata[33:18];
            rx_px.frame_end = s_tlast;
            predict_pixel(rx_px);
            n_px++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.swipe_done = m_tdata[0];
            got.timed_out = m_tdata[1];
            got.zone_now = m_tdata[5:2];
            n_frames++;
            n_swipes += got.swipe_done;
            n_timeouts += got.timed_out;
            if (swipe_q.size() == 0)
            begin
                $error("result with nothing expected: m_tdata=%h", m_tdata);
                err_cnt++;
            end
            else
            begin
                want = swipe_q.pop_front();
                if (got.swipe_done !== want.swipe_done)
                begin
                    $error("swipe_done expected %0d actual %0d", want.swipe_done, got.swipe_done);
                    err_cnt++;
                end
                if (got.timed_out !== want.timed_out)
                begin
                    $error("timed_out expected %0d actual %0d", want.timed_out, got.timed_out);
                    err_cnt++;
                end
                if (got.zone_now !== want.zone_now)
                begin
                    $error("zone_now expected %0d actual %0d", want.zone_now, got.zone_now);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= dszs_pkg::REG_ZONE_COUNT;
        cfg_data <= '0;
        cfg_m.zone_count = dszs_pkg::RST_ZONE_COUNT;
        cfg_m.zone_width = dszs_pkg::RST_ZONE_WIDTH;
        cfg_m.band_top = dszs_pkg::RST_BAND_TOP;
        cfg_m.band_height = dszs_pkg::RST_BAND_HEIGHT;
        cfg_m.near_limit = dszs_pkg::RST_NEAR_LIMIT;
        cfg_m.frame_period = dszs_pkg::RST_FRAME_PERIOD;
        cfg_m.timeout_limit = dszs_pkg::RST_TIMEOUT_LIMIT;
        zone_idx = '0;
        zone_base = '0;
        zone_clock = '0;
        hit_flag = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames on the reset setup
        add_px(0, 0, 1, 0);            // near pixel in zone 0
        add_px(511, 511, 65535, 1);    // far corner ends the frame, zone 0 -> 1
        add_px(128, 127, 1199, 1);     // frame end pixel hits by itself
        add_px(256, 128, 500, 1);      // just below the band
        add_px(256, 5, 1200, 1);       // depth at the near limit
        add_px(300, 5, 0, 1);          // no reading
        add_px(383, 0, 1199, 0);
        add_px(0, 0, 0, 1);
        add_px(384, 10, 700, 1);       // last zone hit, swipe
        add_px(127, 64, 2, 0);
        add_px(128, 64, 2, 1);
        add_px(0, 0, 0, 0);
        add_px(255, 127, 1, 1);
        drain();

        // lowest settings: zone count zero acts as one, timer never moves
        setup = '{zone_count: 5'd0, zone_width: 10'd1, band_top: 9'd0, band_height: 10'd1,
                  near_limit: 16'hFFFF, frame_period: 16'd0, timeout_limit: 16'd0};
        apply_setup(setup);
        queue_frames(60);
        drain();

        // highest settings: zone count saturates, no hit possible
        tx_idle_pct = 52;
        setup = '{zone_count: 5'd31, zone_width: 10'd512, band_top: 9'd511,
                  band_height: 10'd512, near_limit: 16'd0, frame_period: 16'hFFFF,
                  timeout_limit: 16'hFFFF};
        apply_setup(setup);
        queue_frames(50);
        drain();

        // many narrow zones with a tight timer
        tx_idle_pct = 0;
        rx_stall_pct = 52;
        setup = '{zone_count: 5'd16, zone_width: 10'd32, band_top: 9'd100,
                  band_height: 10'd200, near_limit: 16'd3000, frame_period: 16'd100,
                  timeout_limit: 16'd350};
        apply_setup(setup);
        queue_frames(90);
        drain();

        // zero zone width: only timeouts
        tx_idle_pct = 24;
        rx_stall_pct = 24;
        setup = '{zone_count: 5'd3, zone_width: 10'd0, band_top: 9'd0, band_height: 10'd512,
                  near_limit: 16'hFFFF, frame_period: 16'd1000, timeout_limit: 16'd2500};
        apply_setup(setup);
        queue_frames(40);
        drain();

        // receiver holds off while pixels keep coming, frame ends back up
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        setup = '{zone_count: 5'd2, zone_width: 10'd256, band_top: 9'd0, band_height: 10'd512,
                  near_limit: 16'd40000, frame_period: 16'd10, timeout_limit: 16'hFFFF};
        apply_setup(setup);
        hold_req <= 1'b1;
        queue_frames(60);
        drain();

        // random setups across all idling modes
        for (int k = 0; k < 4; k++)
        begin
            tx_idle_pct = (k == 1 || k == 3) ? ((k == 3) ? 24 : 52) : 0;
            rx_stall_pct = (k == 2) ? 52 : ((k == 3) ? 24 : 0);
            setup.zone_count = 5'($urandom_range(6, 1));
            setup.zone_width = 10'($urandom_range(200, 16));
            setup.band_top = 9'($urandom_range(200));
            setup.band_height = 10'($urandom_range(300, 1));
            setup.near_limit = 16'($urandom_range(65535, 1));
            setup.frame_period = 16'($urandom_range(500));
            setup.timeout_limit = 16'($urandom_range(3000));
            apply_setup(setup);
            queue_frames(40);
            drain();
        end

        $display("run covered %0d pixels and %0d frame results (%0d swipes, %0d timeouts)",
                 n_px, n_frames, n_swipes, n_timeouts);
        $display("over %0d register setups, %0d mismatches", n_setups, err_cnt);
        if (err_cnt == 0)
            $display("[depth_swipe_zone_sequencer] OK");
        else
            $display("[depth_swipe_zone_sequencer] ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/dszs_pkg.sv
sv/dszs_hit.sv
sv/depth_swipe_zone_sequencer.sv
bench/depth_swipe_zone_sequencer_tb.sv
